/* design/ats_pkg.sv */
// Shared constants and codes for the alias table sampler.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;
  localparam int MAX_ENTRIES   = 256;
  localparam int IDX_BITS      = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS      = $clog2(MAX_ENTRIES + 1);
  localparam int WEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int UNIFORM_BITS  = 16;
  localparam int SUM_BITS      = WEIGHT_BITS + IDX_BITS;
  localparam int PROD_BITS     = WEIGHT_BITS + CNT_BITS;
  localparam int PROB_BITS     = FRACTION_BITS + CNT_BITS;
  localparam int DVD_BITS      = PROD_BITS + FRACTION_BITS;
  localparam int STEP_BITS     = $clog2(DVD_BITS);

  localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_DRAW  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUILT     = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_ZERO_SUM  = 2'd3
  } status_e;
endpackage
`default_nettype wire

/* design/ats_divider.sv */
// Bit-serial restoring divider: floor(num * 2^FRACTION_BITS / den).
`timescale 1ns / 1ps
`default_nettype none
module ats_divider (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [ats_pkg::PROD_BITS-1:0]  num_i,
  input  wire logic [ats_pkg::SUM_BITS-1:0]   den_i,
  output logic                                done_o,
  output logic [ats_pkg::PROB_BITS-1:0]       quo_o
);
  logic                              busy_q, busy_d, done_q, done_d;
  logic [ats_pkg::STEP_BITS-1:0]     cnt_q, cnt_d;
  logic [ats_pkg::DVD_BITS-1:0]      dvd_q, dvd_d;
  logic [ats_pkg::SUM_BITS-1:0]      rem_q, rem_d;
  logic [ats_pkg::SUM_BITS-1:0]      den_q, den_d;
  logic [ats_pkg::PROB_BITS-1:0]     quo_q, quo_d;
  logic [ats_pkg::SUM_BITS:0]        trial;
  logic                              fits;

  assign trial = {rem_q, dvd_q[ats_pkg::DVD_BITS-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ats_pkg::STEP_BITS'(ats_pkg::DVD_BITS - 1);
      dvd_d  = {num_i, {ats_pkg::FRACTION_BITS{1'b0}}};
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[ats_pkg::DVD_BITS-2:0], 1'b0};
      rem_d = fits ? ats_pkg::SUM_BITS'(trial - {1'b0, den_q})
                   : trial[ats_pkg::SUM_BITS-1:0];
      quo_d = {quo_q[ats_pkg::PROB_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

/* design/alias_table_sampler.sv */
// Walker alias-method sampler: weight store, table build sequencer, draw path.
//
// Input channel: in_valid_i / in_stall_o, one beat per item (operation,
// entry_index, weight, uniform_u, uniform_v). Output channel: out_valid_o /
// out_stall_i, one beat per item (sample_index, status). The user writes
// table_size through table_size_we_i / table_size_i only while the block is
// idle; the block does not enforce this. One item at a time: in_stall_o is
// high from acceptance until the result is moved into the output register.
// From acceptance to result: load, clear and refused items go straight to the
// response; a draw does the column multiply at acceptance, then the table
// read and the compare. A build sums the weights, then for each entry reads,
// multiplies, runs 41 divider steps in the shared bit-serial divider and
// writes, then does the alias pairings, at most n of them.
// Reset clears the sequencer, the counters, the built flag and the output
// valid flag; table_size returns to 1. The memories are not cleared: a build
// zeroes the alias links of the entries it covers.
// While the receiver stalls, the result stays in the output register. The
// block can still take one new item; its result waits for that beat to go.
`timescale 1ns / 1ps
`default_nettype none
module alias_table_sampler (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              table_size_we_i,
  input  wire logic [ats_pkg::CNT_BITS-1:0]      table_size_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        operation_i,
  input  wire logic [ats_pkg::IDX_BITS-1:0]      entry_index_i,
  input  wire logic [ats_pkg::WEIGHT_BITS-1:0]   weight_i,
  input  wire logic [ats_pkg::UNIFORM_BITS-1:0]  uniform_u_i,
  input  wire logic [ats_pkg::UNIFORM_BITS-1:0]  uniform_v_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ats_pkg::IDX_BITS-1:0]           sample_index_o,
  output logic [1:0]                             status_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_SUM_RD, S_SUM_ACC, S_SC_RD, S_SC_MUL, S_DIV, S_SC_WR,
    S_PR_CHK, S_PR_RDP, S_PR_RDH, S_PR_WR, S_DR_RD, S_DR_CMP, S_RESP
  } state_e;

  localparam int IB = ats_pkg::IDX_BITS;
  localparam int CB = ats_pkg::CNT_BITS;
  localparam int PB = ats_pkg::PROB_BITS;

  state_e                          state_q, state_d;
  logic [CB-1:0]                   table_size_q;
  logic [CB-1:0]                   n_q, n_d, built_n_q, built_n_d;
  logic [CB-1:0]                   sc_q, sc_d, lc_q, lc_d;
  logic                            built_q, built_d;
  logic [IB-1:0]                   idx_q, idx_d, col_q, col_d;
  logic [IB-1:0]                   lo_q, lo_d, hi_q, hi_d;
  logic [ats_pkg::SUM_BITS-1:0]    sum_q, sum_d;
  logic [PB-1:0]                   plo_q, plo_d;
  logic [ats_pkg::UNIFORM_BITS-1:0] v_q, v_d;
  logic [IB-1:0]                   res_sample_q, res_sample_d;
  ats_pkg::status_e                res_status_q, res_status_d;
  logic                            out_valid_q, out_valid_d;
  logic [IB-1:0]                   sample_q, sample_d;
  ats_pkg::status_e                status_q, status_d;

  // memories
  logic [ats_pkg::WEIGHT_BITS-1:0] weight_mem [ats_pkg::MAX_ENTRIES];
  logic [PB-1:0]                   prob_mem   [ats_pkg::MAX_ENTRIES];
  logic [IB-1:0]                   alias_mem  [ats_pkg::MAX_ENTRIES];
  logic [IB-1:0]                   small_mem  [ats_pkg::MAX_ENTRIES];
  logic [IB-1:0]                   large_mem  [ats_pkg::MAX_ENTRIES];
  logic [ats_pkg::WEIGHT_BITS-1:0] w_rd_q;
  logic [PB-1:0]                   prob_rd_q;
  logic [IB-1:0]                   alias_rd_q, small_rd_q, large_rd_q;

  logic                            w_we, prob_we, alias_we, small_we, large_we;
  logic [IB-1:0]                   prob_waddr, prob_raddr, alias_waddr, small_waddr;
  logic [PB-1:0]                   prob_wdata;
  logic [IB-1:0]                   alias_wdata, small_wdata;

  logic                            in_acc, out_acc;
  logic [CB-1:0]                   n_eff, sc_m1, lc_m1, n_m1;
  logic                            last_idx;
  logic [ats_pkg::UNIFORM_BITS+CB-1:0] col_prod;
  logic [PB-1:0]                   prob_new;
  logic                            div_start, div_done;
  logic [PB-1:0]                   div_quo;

  ats_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ats_pkg::PROD_BITS'(w_rd_q * n_q)),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign sc_m1    = sc_q - 1'b1;
  assign lc_m1    = lc_q - 1'b1;
  assign n_m1     = n_q - 1'b1;
  assign last_idx = ({1'b0, idx_q} == n_m1);
  assign col_prod = uniform_u_i * built_n_q;
  // prob[hi] - (one - prob[lo]); never negative as prob[hi] >= one
  assign prob_new = prob_rd_q + plo_q - ats_pkg::PROB_ONE;
  assign div_start = (state_q == S_SC_MUL);

  always_comb begin
    if (table_size_q == '0) begin
      n_eff = CB'(1);
    end else if (table_size_q > CB'(ats_pkg::MAX_ENTRIES)) begin
      n_eff = CB'(ats_pkg::MAX_ENTRIES);
    end else begin
      n_eff = table_size_q;
    end
  end

  always_comb begin
    unique case (state_q)
      S_PR_RDP: prob_raddr = small_rd_q;
      S_PR_RDH: prob_raddr = hi_q;
      default:  prob_raddr = col_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    built_n_d    = built_n_q;
    sc_d         = sc_q;
    lc_d         = lc_q;
    built_d      = built_q;
    idx_d        = idx_q;
    col_d        = col_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    sum_d        = sum_q;
    plo_d        = plo_q;
    v_d          = v_q;
    res_sample_d = res_sample_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_acc;
    sample_d     = sample_q;
    status_d     = status_q;
    w_we         = 1'b0;
    prob_we      = 1'b0;
    alias_we     = 1'b0;
    small_we     = 1'b0;
    large_we     = 1'b0;
    prob_waddr   = idx_q;
    prob_wdata   = div_quo;
    alias_waddr  = idx_q;
    alias_wdata  = '0;
    small_waddr  = sc_q[IB-1:0];
    small_wdata  = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_sample_d = '0;
          res_status_d = ats_pkg::ST_OK;
          state_d      = S_RESP;
          v_d          = uniform_v_i;
          unique case (ats_pkg::op_e'(operation_i))
            ats_pkg::OP_LOAD: begin
              w_we = 1'b1;
            end
            ats_pkg::OP_BUILD: begin
              if (built_q) begin
                res_status_d = ats_pkg::ST_BUILT;
              end else begin
                n_d     = n_eff;
                idx_d   = '0;
                sum_d   = '0;
                state_d = S_SUM_RD;
              end
            end
            ats_pkg::OP_DRAW: begin
              if (!built_q) begin
                res_status_d = ats_pkg::ST_NOT_BUILT;
              end else begin
                col_d   = col_prod[ats_pkg::UNIFORM_BITS +: IB];
                state_d = S_DR_RD;
              end
            end
            ats_pkg::OP_CLEAR: begin
              if (!built_q) res_status_d = ats_pkg::ST_NOT_BUILT;
              else built_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SUM_RD: state_d = S_SUM_ACC;
      S_SUM_ACC: begin
        sum_d = sum_q + ats_pkg::SUM_BITS'(w_rd_q);
        if (last_idx) begin
          if (sum_d == '0) begin
            res_status_d = ats_pkg::ST_ZERO_SUM;
            state_d      = S_RESP;
          end else begin
            built_n_d = n_q;
            idx_d     = '0;
            sc_d      = '0;
            lc_d      = '0;
            state_d   = S_SC_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SUM_RD;
        end
      end
      S_SC_RD:  state_d = S_SC_MUL;
      S_SC_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = S_SC_WR;
      end
      S_SC_WR: begin
        prob_we  = 1'b1;
        alias_we = 1'b1;
        if (div_quo < ats_pkg::PROB_ONE) begin
          small_we = 1'b1;
          sc_d     = sc_q + 1'b1;
        end else begin
          large_we = 1'b1;
          lc_d     = lc_q + 1'b1;
        end
        if (last_idx) begin
          state_d = S_PR_CHK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SC_RD;
        end
      end
      S_PR_CHK: begin
        if (sc_q == '0 || lc_q == '0) begin
          built_d = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_PR_RDP;
        end
      end
      S_PR_RDP: begin
        lo_d    = small_rd_q;
        hi_d    = large_rd_q;
        state_d = S_PR_RDH;
      end
      S_PR_RDH: begin
        plo_d   = prob_rd_q;
        state_d = S_PR_WR;
      end
      S_PR_WR: begin
        prob_we     = 1'b1;
        prob_waddr  = hi_q;
        prob_wdata  = prob_new;
        alias_we    = 1'b1;
        alias_waddr = lo_q;
        alias_wdata = hi_q;
        if (prob_new < ats_pkg::PROB_ONE) begin
          // large entry drops below one and replaces the small top
          lc_d        = lc_m1;
          small_we    = 1'b1;
          small_waddr = sc_m1[IB-1:0];
          small_wdata = hi_q;
        end else begin
          sc_d = sc_m1;
        end
        state_d = S_PR_CHK;
      end
      S_DR_RD: state_d = S_DR_CMP;
      S_DR_CMP: begin
        res_sample_d = ({{(PB-ats_pkg::UNIFORM_BITS){1'b0}}, v_q} <= prob_rd_q)
                       ? col_q : alias_rd_q;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          sample_d    = res_sample_q;
          status_d    = res_status_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      table_size_q <= CB'(1);
      n_q          <= CB'(1);
      built_n_q    <= CB'(1);
      sc_q         <= '0;
      lc_q         <= '0;
      built_q      <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (table_size_we_i) table_size_q <= table_size_i;
      n_q          <= n_d;
      built_n_q    <= built_n_d;
      sc_q         <= sc_d;
      lc_q         <= lc_d;
      built_q      <= built_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    sum_q        <= sum_d;
    plo_q        <= plo_d;
    v_q          <= v_d;
    res_sample_q <= res_sample_d;
    res_status_q <= res_status_d;
    sample_q     <= sample_d;
    status_q     <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (w_we) weight_mem[entry_index_i] <= weight_i;
    w_rd_q <= weight_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (prob_we) prob_mem[prob_waddr] <= prob_wdata;
    prob_rd_q <= prob_mem[prob_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (alias_we) alias_mem[alias_waddr] <= alias_wdata;
    alias_rd_q <= alias_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (small_we) small_mem[small_waddr] <= small_wdata;
    small_rd_q <= small_mem[sc_m1[IB-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (large_we) large_mem[lc_q[IB-1:0]] <= idx_q;
    large_rd_q <= large_mem[lc_m1[IB-1:0]];
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sample_index_o = sample_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  // the two stacks together never hold more than MAX_ENTRIES entries
  a_stack_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, sc_q} + {1'b0, lc_q}) <= (CB+1)'(ats_pkg::MAX_ENTRIES))
    else $error("stack counts exceed table depth");
  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result outside the divide step");
  // any result with a status other than ST_OK carries a zero index
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ats_pkg::ST_OK) |-> (sample_index_o == '0))
    else $error("non-zero index with error status");
`endif
endmodule
`default_nettype wire
